/* rtl/tsd_pkg.sv */
// Shared types, constants and table functions of the timestamp difference block.
package tsd_pkg;

   localparam int unsigned DAY_W  = 16;   // day count since 2000, up to year offset 127
   localparam int unsigned TOD_W  = 27;   // ms of day, fields at face value
   localparam int unsigned PROD_W = 44;   // signed day difference times ms per day
   localparam int unsigned EXACT_W = 45;  // signed exact difference

   localparam logic [TOD_W-1:0] MS_PER_HOUR   = TOD_W'(3600000);
   localparam logic [TOD_W-1:0] MS_PER_MINUTE = TOD_W'(60000);
   localparam logic signed [TOD_W:0] MS_PER_DAY = (TOD_W+1)'(86400000);

   localparam logic [8:0] DAYS_LEAP   = 9'd366;
   localparam logic [8:0] DAYS_COMMON = 9'd365;
   localparam logic [6:0] YEAR_2100   = 7'd100;

   typedef struct packed {
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] millis;
   } stamp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTHS,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;         // capture both stamps, clear sums
      logic year_step;    // add one year length to each sum still short of its year
      logic month_start;  // add day of month, restart counter at January
      logic month_step;   // add one month length to each sum still short of its month
      logic multiply;     // day difference times ms per day, ms-of-day difference
      logic publish;      // final sum into the output register
   } cmd_type;

   typedef struct packed {
      logic years_done;
      logic months_done;
      logic out_free;
   } status_type;

   // Gregorian rule on 2000 + offset; within 0..127 only 2100 breaks the rule of four.
   function automatic logic leap_of(input logic [6:0] year);
      return (year[1:0] == 2'b00) && (year != YEAR_2100);
   endfunction

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/tsd_ctrl.sv */
// Sequencer of the timestamp difference block: years, months, multiply, publish.
module tsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tsd_pkg::status_type    status,
   output tsd_pkg::cmd_type       cmd
);

   tsd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsd_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tsd_pkg::ST_YEARS;
         end
         tsd_pkg::ST_YEARS: begin
            if (status.years_done) state_in = tsd_pkg::ST_MONTHS;
         end
         tsd_pkg::ST_MONTHS: begin
            if (status.months_done) state_in = tsd_pkg::ST_MULTIPLY;
         end
         tsd_pkg::ST_MULTIPLY: begin
            state_in = tsd_pkg::ST_FINISH;
         end
         tsd_pkg::ST_FINISH: begin
            if (status.out_free) state_in = tsd_pkg::ST_IDLE;
         end
         default: state_in = tsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tsd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         tsd_pkg::ST_YEARS: begin
            cmd.year_step   = !status.years_done;
            cmd.month_start = status.years_done;
         end
         tsd_pkg::ST_MONTHS: begin
            cmd.month_step = !status.months_done;
         end
         tsd_pkg::ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
         end
         tsd_pkg::ST_FINISH: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/tsd_datapath.sv */
// Datapath: day sums, ms-of-day values, day product and the output register.
module tsd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tsd_pkg::stamp_type     first_stamp,
   input  tsd_pkg::stamp_type     second_stamp,
   input  tsd_pkg::cmd_type       cmd,
   output tsd_pkg::status_type    status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            difference_ms,
   output logic                   overflowed
);

   localparam int unsigned DW = tsd_pkg::DAY_W;
   localparam int unsigned TW = tsd_pkg::TOD_W;

   tsd_pkg::stamp_type first_ff, second_ff;
   logic [6:0]                      cnt_ff;
   logic [DW-1:0]                   days1_ff, days2_ff;
   logic [TW-1:0]                   tod1_ff, tod2_ff;
   logic [TW-1:0]                   tod1_in, tod2_in;
   logic signed [tsd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [TW:0]              tod_diff_ff, tod_diff_in;
   logic signed [DW:0]              day_delta;
   logic signed [tsd_pkg::EXACT_W-1:0] exact;
   logic                            leap1, leap2, year_leap;
   logic [8:0]                      year_len;
   logic [4:0]                      mlen1, mlen2;
   logic                            valid_ff;
   logic [31:0]                     diff_ff;
   logic                            ovf_ff, ovf_in;

   assign tod1_in = TW'(first_stamp.hour) * tsd_pkg::MS_PER_HOUR
                  + TW'(first_stamp.minute) * tsd_pkg::MS_PER_MINUTE
                  + TW'(first_stamp.millis);
   assign tod2_in = TW'(second_stamp.hour) * tsd_pkg::MS_PER_HOUR
                  + TW'(second_stamp.minute) * tsd_pkg::MS_PER_MINUTE
                  + TW'(second_stamp.millis);

   // the year being counted is the same for both sums
   assign year_leap = tsd_pkg::leap_of(cnt_ff);
   assign year_len  = year_leap ? tsd_pkg::DAYS_LEAP : tsd_pkg::DAYS_COMMON;
   assign leap1     = tsd_pkg::leap_of(first_ff.year);
   assign leap2     = tsd_pkg::leap_of(second_ff.year);
   assign mlen1     = tsd_pkg::month_len(leap1, cnt_ff[3:0]);
   assign mlen2     = tsd_pkg::month_len(leap2, cnt_ff[3:0]);

   assign day_delta   = $signed({1'b0, days1_ff}) - $signed({1'b0, days2_ff});
   assign prod_in     = day_delta * tsd_pkg::MS_PER_DAY;
   assign tod_diff_in = $signed({1'b0, tod1_ff}) - $signed({1'b0, tod2_ff});
   assign exact       = tsd_pkg::EXACT_W'(prod_ff) + tsd_pkg::EXACT_W'(tod_diff_ff);
   // fits in 32 bits only when bits 44..31 are all equal
   assign ovf_in      = !((&exact[tsd_pkg::EXACT_W-1:31]) || !(|exact[tsd_pkg::EXACT_W-1:31]));

   assign status.years_done  = (cnt_ff >= first_ff.year) && (cnt_ff >= second_ff.year);
   assign status.months_done = (cnt_ff >= {3'b000, first_ff.month})
                            && (cnt_ff >= {3'b000, second_ff.month});
   assign status.out_free    = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff  <= first_stamp;
         second_ff <= second_stamp;
         tod1_ff   <= tod1_in;
         tod2_ff   <= tod2_in;
         cnt_ff    <= '0;
         days1_ff  <= '0;
         days2_ff  <= '0;
      end else if (cmd.year_step) begin
         if (cnt_ff < first_ff.year)  days1_ff <= days1_ff + DW'(year_len);
         if (cnt_ff < second_ff.year) days2_ff <= days2_ff + DW'(year_len);
         cnt_ff <= cnt_ff + 7'd1;
      end else if (cmd.month_start) begin
         days1_ff <= days1_ff + DW'(first_ff.day);
         days2_ff <= days2_ff + DW'(second_ff.day);
         cnt_ff   <= 7'd1;
      end else if (cmd.month_step) begin
         if (cnt_ff < {3'b000, first_ff.month})  days1_ff <= days1_ff + DW'(mlen1);
         if (cnt_ff < {3'b000, second_ff.month}) days2_ff <= days2_ff + DW'(mlen2);
         cnt_ff <= cnt_ff + 7'd1;
      end
      if (cmd.multiply) begin
         prod_ff     <= prod_in;
         tod_diff_ff <= tod_diff_in;
      end
      if (cmd.publish) begin
         diff_ff <= exact[31:0];
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign difference_ms = diff_ff;
   assign overflowed    = ovf_ff;

endmodule

/* rtl/timestamp_difference_ms.sv */
// Top level: signed millisecond difference of two calendar timestamps.
//
// Usage: one transfer on req_ carries both timestamps (first minus second is
// returned). One transfer on rsp_ carries the 32-bit wrapped difference in
// rsp_tdata and an overflow flag in rsp_tuser.
// The day counts step one year per cycle, add the day of month, then step one
// month per cycle through a shared counter; the day product is registered in
// its own state, and the publish into the output register follows.
// One item is in work at a time; req_tready is high only while the sequencer is
// idle, so the next request is taken at the earliest in the cycle after a publish.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits on rsp_tready. If the receiver stalls long
// enough, the next result waits in the sequencer until the register frees.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_tvalid; no other state survives an item.
module timestamp_difference_ms (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] first_millis, [21:16] first_minute, [26:22] first_hour,
   // [31:27] first_day, [35:32] first_month, [42:36] first_year,
   // [58:43] second_millis, [64:59] second_minute, [69:65] second_hour,
   // [74:70] second_day, [78:75] second_month, [85:79] second_year, [87:86] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] difference_ms
   output logic [31:0] rsp_tdata,
   // [0] overflowed
   output logic        rsp_tuser
);

   tsd_pkg::stamp_type  first_stamp, second_stamp;
   tsd_pkg::cmd_type    cmd;
   tsd_pkg::status_type status;

   always_comb begin
      first_stamp.millis  = req_tdata[15:0];
      first_stamp.minute  = req_tdata[21:16];
      first_stamp.hour    = req_tdata[26:22];
      first_stamp.day     = req_tdata[31:27];
      first_stamp.month   = req_tdata[35:32];
      first_stamp.year    = req_tdata[42:36];
      second_stamp.millis = req_tdata[58:43];
      second_stamp.minute = req_tdata[64:59];
      second_stamp.hour   = req_tdata[69:65];
      second_stamp.day    = req_tdata[74:70];
      second_stamp.month  = req_tdata[78:75];
      second_stamp.year   = req_tdata[85:79];
   end

   tsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tsd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .first_stamp   (first_stamp),
      .second_stamp  (second_stamp),
      .cmd           (cmd),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .difference_ms (rsp_tdata),
      .overflowed    (rsp_tuser)
   );

   // at most one datapath command in any cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("tsd: overlapping datapath commands");

   // a taken request blocks further requests until its result is published
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("tsd: request taken while an item is in work");

   // a fresh result only follows a publish command
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.publish))
      else $error("tsd: result valid without publish");

   // publishing only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("tsd: result overwritten before transfer");

endmodule

/* tb/tb_timestamp_difference_ms.sv */
// Self-checking bench for timestamp_difference_ms: directed corners, then random pairs.
`timescale 1ns / 100ps

module tb_timestamp_difference_ms;

   localparam int CLOCK_PERIOD = 10;
   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASES = 4;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam longint MS_DAY = 86400000;
   localparam longint MS_HOUR = 3600000;
   localparam longint MS_MINUTE = 60000;
   localparam longint DIFF_HIGH = 64'sd2147483647;
   localparam longint DIFF_LOW = -64'sd2147483648;
   // non-leap month lengths, entries past December count nothing
   localparam int unsigned MONTH_DAYS [16] = '{0, 31, 28, 31, 30, 31, 30, 31,
                                               31, 30, 31, 30, 31, 0, 0, 0};
   // per phase: sender idle and receiver stall, percent of cycles
   localparam int unsigned SEND_IDLE [PHASES] = '{0, 65, 0, 13};
   localparam int unsigned RECV_STALL [PHASES] = '{0, 0, 65, 13};

   typedef struct {
      logic [31:0] diff_ms;
      logic        overflow;
   } diff_result_type;

   class diff_scoreboard;
      diff_result_type expected_diffs[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      static function bit leap_year(int unsigned offset);
         int unsigned y;
         y = 2000 + offset;
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function longint day_number(tsd_pkg::stamp_type s);
         longint days;
         days = 0;
         for (int unsigned y = 0; y < s.year; y++)
            days += leap_year(y) ? 366 : 365;
         for (int unsigned m = 1; m < s.month; m++) begin
            days += MONTH_DAYS[m];
            if (m == 2 && leap_year(s.year))
               days += 1;
         end
         return days + s.day;
      endfunction

      static function longint ms_of_day(tsd_pkg::stamp_type s);
         return longint'(s.hour) * MS_HOUR + longint'(s.minute) * MS_MINUTE
                + longint'(s.millis);
      endfunction

      function void add_request(tsd_pkg::stamp_type first, tsd_pkg::stamp_type second);
         longint exact;
         diff_result_type r;
         exact = (day_number(first) - day_number(second)) * MS_DAY
                 + ms_of_day(first) - ms_of_day(second);
         r.diff_ms = exact[31:0];
         r.overflow = (exact > DIFF_HIGH) || (exact < DIFF_LOW);
         expected_diffs.push_back(r);
      endfunction

      function void check_response(logic [31:0] diff_ms, logic overflow);
         diff_result_type want;
         if (expected_diffs.size() == 0) begin
            $display("%0t: unexpected result, diff %0d overflow %0b", $time,
                     $signed(diff_ms), overflow);
            errors++;
            return;
         end
         want = expected_diffs.pop_front();
         if (diff_ms !== want.diff_ms) begin
            $display("%0t: difference_ms expected %0d actual %0d", $time,
                     $signed(want.diff_ms), $signed(diff_ms));
            errors++;
         end
         if (overflow !== want.overflow) begin
            $display("%0t: overflowed expected %0b actual %0b", $time,
                     want.overflow, overflow);
            errors++;
         end
      endfunction

      function int pending();
         return expected_diffs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   longint      cycles = 0;
   diff_scoreboard sb;

   timestamp_difference_ms dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic tsd_pkg::stamp_type make_stamp(int unsigned year, int unsigned month,
                                                     int unsigned day, int unsigned hour,
                                                     int unsigned minute,
                                                     int unsigned millis);
      tsd_pkg::stamp_type s;
      s.year = year[6:0];
      s.month = month[3:0];
      s.day = day[4:0];
      s.hour = hour[4:0];
      s.minute = minute[5:0];
      s.millis = millis[15:0];
      return s;
   endfunction

   function automatic tsd_pkg::stamp_type random_stamp(bit full_width);
      tsd_pkg::stamp_type s;
      if (full_width)
         s = make_stamp($urandom_range(127), $urandom_range(15), $urandom_range(31),
                        $urandom_range(31), $urandom_range(63), $urandom_range(65535));
      else
         s = make_stamp($urandom_range(99), $urandom_range(12, 1), $urandom_range(31, 1),
                        $urandom_range(23), $urandom_range(59), $urandom_range(59999));
      return s;
   endfunction

   // caller sits at a falling edge; returns at the falling edge after the transfer
   task automatic send_pair(tsd_pkg::stamp_type first, tsd_pkg::stamp_type second);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, second, first};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.add_request(first, second);
      @(negedge clock);
   endtask

   task automatic random_pair();
      int unsigned kind;
      tsd_pkg::stamp_type a;
      tsd_pkg::stamp_type b;
      kind = $urandom_range(99);
      a = random_stamp(1'b0);
      if (kind < 40) begin
         // same month: differences under a month, which can still leave the 32-bit range
         b = a;
         b.day = 5'($urandom_range(28, 1));
         b.hour = 5'($urandom_range(23));
         b.minute = 6'($urandom_range(59));
         b.millis = 16'($urandom_range(59999));
      end else if (kind < 85) begin
         b = random_stamp(1'b0);
      end else begin
         a = random_stamp(1'b1);
         b = random_stamp(1'($urandom_range(1)));
      end
      if ($urandom_range(1))
         send_pair(a, b);
      else
         send_pair(b, a);
   endtask

   task automatic wait_results();
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_pair(make_stamp(0, 0, 0, 0, 0, 0), make_stamp(0, 0, 0, 0, 0, 0));
      send_pair(make_stamp(23, 6, 15, 12, 30, 30000), make_stamp(23, 6, 15, 12, 30, 30000));
      send_pair(make_stamp(99, 12, 31, 23, 59, 59999), make_stamp(0, 1, 1, 0, 0, 0));
      send_pair(make_stamp(0, 1, 1, 0, 0, 0), make_stamp(99, 12, 31, 23, 59, 59999));
      // right at the signed 32-bit limits and one past
      send_pair(make_stamp(0, 1, 25, 20, 31, 23647), make_stamp(0, 1, 1, 0, 0, 0));
      send_pair(make_stamp(0, 1, 25, 20, 31, 23648), make_stamp(0, 1, 1, 0, 0, 0));
      send_pair(make_stamp(0, 1, 1, 0, 0, 0), make_stamp(0, 1, 25, 20, 31, 23648));
      send_pair(make_stamp(0, 1, 1, 0, 0, 0), make_stamp(0, 1, 25, 20, 31, 23649));
      // leap days: 2000 and 2004 leap, 2100 not
      send_pair(make_stamp(0, 3, 1, 0, 0, 0), make_stamp(0, 2, 29, 0, 0, 0));
      send_pair(make_stamp(100, 3, 1, 0, 0, 0), make_stamp(100, 2, 28, 23, 59, 59999));
      send_pair(make_stamp(4, 3, 1, 0, 0, 0), make_stamp(4, 2, 29, 12, 0, 0));
      send_pair(make_stamp(1, 1, 1, 0, 0, 0), make_stamp(0, 12, 31, 23, 59, 59999));
      // month zero, months past December, day zero, day past month end
      send_pair(make_stamp(10, 0, 5, 1, 2, 3), make_stamp(10, 1, 5, 1, 2, 3));
      send_pair(make_stamp(10, 13, 1, 0, 0, 0), make_stamp(10, 12, 31, 0, 0, 0));
      send_pair(make_stamp(10, 15, 0, 0, 0, 0), make_stamp(11, 1, 0, 0, 0, 0));
      send_pair(make_stamp(5, 2, 31, 6, 0, 0), make_stamp(5, 3, 3, 6, 0, 0));
      // every field at full width
      send_pair(make_stamp(127, 15, 31, 31, 63, 65535), make_stamp(0, 0, 0, 0, 0, 0));
      send_pair(make_stamp(0, 0, 0, 0, 0, 0), make_stamp(127, 15, 31, 31, 63, 65535));
      send_pair(make_stamp(50, 6, 10, 5, 5, 65535), make_stamp(50, 6, 10, 5, 6, 0));
      send_pair(make_stamp(127, 1, 1, 0, 0, 0), make_stamp(126, 12, 31, 23, 59, 59999));
      req_tvalid = 1'b0;
      wait_results();

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = SEND_IDLE[p];
         rsp_stall_pct = RECV_STALL[p];
         repeat (RANDOM_ITEMS / PHASES) random_pair();
         // sender holds off until the block has returned everything
         req_tvalid = 1'b0;
         wait_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
